>>> hdl/ipf_pkg.sv
// ipf_pkg: types, widths, codes and the solve sequence used by image_plane_fit.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package ipf_pkg;

  // Default sizing
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_FRAC_BITS   = 16;

  // Field widths
  localparam int Z_W  = 16;   // sample width
  localparam int RD_W = 11;   // rows_done width
  localparam int QW   = 48;   // result width

  // Running sums hold the largest sum at 4096 x 4096 samples
  localparam int SUM_W = 54;
  // Exact cofactor, determinant and numerator width
  localparam int ACC_W = 192;

  // Solve sequence
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] LINE_START = 5'd24;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PLANE = 2'd1,
    KIND_LINE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_MAC,
    S_DIVGO,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_N, OP_SX, OP_SY, OP_SXX, OP_SYY, OP_SXY, OP_SXZ, OP_SYZ, OP_SZ,
    OP_A11, OP_A12, OP_A13, OP_A22, OP_A23, OP_A33
  } opnd_t;

  typedef enum logic [3:0] {
    D_NONE, D_A11, D_A12, D_A13, D_A22, D_A23, D_A33, D_DET, D_NUM
  } dest_t;

  typedef enum logic [1:0] {
    SL_A, SL_B, SL_C
  } slot_t;

  typedef struct packed {
    opnd_t xsel;
    opnd_t bsel;
    logic  neg;
    logic  first;
    logic  last;
    dest_t dest;
    slot_t slot;
    logic  done;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mac_ctl_t;

  typedef struct packed {
    logic [SUM_W-1:0] n;
    logic [SUM_W-1:0] sx;
    logic [SUM_W-1:0] sy;
    logic [SUM_W-1:0] sxx;
    logic [SUM_W-1:0] syy;
    logic [SUM_W-1:0] sxy;
    logic [SUM_W-1:0] sxz;
    logic [SUM_W-1:0] syz;
    logic [SUM_W-1:0] sz;
  } sums_t;

  function automatic ucode_t mk(input opnd_t x, input opnd_t b, input logic ng,
                                input logic fs, input logic ls, input dest_t d,
                                input slot_t sl, input logic dn);
    ucode_t u;
    u.xsel  = x;
    u.bsel  = b;
    u.neg   = ng;
    u.first = fs;
    u.last  = ls;
    u.dest  = d;
    u.slot  = sl;
    u.done  = dn;
    return u;
  endfunction

  // One multiply-accumulate term per step
  function automatic ucode_t ucode(input logic [STEP_W-1:0] s);
    ucode_t u;
    case (s)
      5'd0:  u = mk(OP_SYY, OP_N,   1'b0, 1'b1, 1'b0, D_NONE, SL_A, 1'b0);
      5'd1:  u = mk(OP_SY,  OP_SY,  1'b1, 1'b0, 1'b1, D_A11,  SL_A, 1'b0);
      5'd2:  u = mk(OP_SX,  OP_SY,  1'b0, 1'b1, 1'b0, D_NONE, SL_A, 1'b0);
      5'd3:  u = mk(OP_SXY, OP_N,   1'b1, 1'b0, 1'b1, D_A12,  SL_A, 1'b0);
      5'd4:  u = mk(OP_SXY, OP_SY,  1'b0, 1'b1, 1'b0, D_NONE, SL_A, 1'b0);
      5'd5:  u = mk(OP_SX,  OP_SYY, 1'b1, 1'b0, 1'b1, D_A13,  SL_A, 1'b0);
      5'd6:  u = mk(OP_SXX, OP_N,   1'b0, 1'b1, 1'b0, D_NONE, SL_A, 1'b0);
      5'd7:  u = mk(OP_SX,  OP_SX,  1'b1, 1'b0, 1'b1, D_A22,  SL_A, 1'b0);
      5'd8:  u = mk(OP_SX,  OP_SXY, 1'b0, 1'b1, 1'b0, D_NONE, SL_A, 1'b0);
      5'd9:  u = mk(OP_SXX, OP_SY,  1'b1, 1'b0, 1'b1, D_A23,  SL_A, 1'b0);
      5'd10: u = mk(OP_SXX, OP_SYY, 1'b0, 1'b1, 1'b0, D_NONE, SL_A, 1'b0);
      5'd11: u = mk(OP_SXY, OP_SXY, 1'b1, 1'b0, 1'b1, D_A33,  SL_A, 1'b0);
      5'd12: u = mk(OP_A11, OP_SXX, 1'b0, 1'b1, 1'b0, D_NONE, SL_A, 1'b0);
      5'd13: u = mk(OP_A12, OP_SXY, 1'b0, 1'b0, 1'b0, D_NONE, SL_A, 1'b0);
      5'd14: u = mk(OP_A13, OP_SX,  1'b0, 1'b0, 1'b1, D_DET,  SL_A, 1'b0);
      5'd15: u = mk(OP_A11, OP_SXZ, 1'b0, 1'b1, 1'b0, D_NONE, SL_A, 1'b0);
      5'd16: u = mk(OP_A12, OP_SYZ, 1'b0, 1'b0, 1'b0, D_NONE, SL_A, 1'b0);
      5'd17: u = mk(OP_A13, OP_SZ,  1'b0, 1'b0, 1'b1, D_NUM,  SL_A, 1'b0);
      5'd18: u = mk(OP_A12, OP_SXZ, 1'b0, 1'b1, 1'b0, D_NONE, SL_B, 1'b0);
      5'd19: u = mk(OP_A22, OP_SYZ, 1'b0, 1'b0, 1'b0, D_NONE, SL_B, 1'b0);
      5'd20: u = mk(OP_A23, OP_SZ,  1'b0, 1'b0, 1'b1, D_NUM,  SL_B, 1'b0);
      5'd21: u = mk(OP_A13, OP_SXZ, 1'b0, 1'b1, 1'b0, D_NONE, SL_C, 1'b0);
      5'd22: u = mk(OP_A23, OP_SYZ, 1'b0, 1'b0, 1'b0, D_NONE, SL_C, 1'b0);
      5'd23: u = mk(OP_A33, OP_SZ,  1'b0, 1'b0, 1'b1, D_NUM,  SL_C, 1'b1);
      // line fallback
      5'd24: u = mk(OP_N,   OP_SXZ, 1'b0, 1'b1, 1'b0, D_NONE, SL_A, 1'b0);
      5'd25: u = mk(OP_SX,  OP_SZ,  1'b1, 1'b0, 1'b1, D_NUM,  SL_A, 1'b0);
      5'd26: u = mk(OP_SXX, OP_SZ,  1'b0, 1'b1, 1'b0, D_NONE, SL_C, 1'b0);
      5'd27: u = mk(OP_SX,  OP_SXZ, 1'b1, 1'b0, 1'b1, D_NUM,  SL_C, 1'b1);
      default: u = mk(OP_N, OP_N,   1'b0, 1'b1, 1'b1, D_NUM,  SL_C, 1'b1);
    endcase
    return u;
  endfunction

endpackage

>>> hdl/ipf_accum.sv
// ipf_accum: column/row counters and the nine running sums, two-stage.
// Depends on ipf_pkg.
`timescale 1ns / 1ps

module ipf_accum #(
  parameter int MAX_COLUMNS = ipf_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = ipf_pkg::DEF_MAX_ROWS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic signed [ipf_pkg::Z_W-1:0]       sample,
  input  logic                                 sample_valid,
  input  logic                                 first_of_image,
  input  logic                                 last_of_row,
  input  logic                                 scan_down,
  output logic                                 solve_go,
  output ipf_pkg::sums_t                       sums,
  output logic [$clog2(MAX_ROWS+1)-1:0]        row_count
);

  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int YW  = RCW + 1;
  localparam int ZW  = ipf_pkg::Z_W;
  localparam int SW  = ipf_pkg::SUM_W;

  logic [CW-1:0]         col_r, col_nxt, col0;
  logic [RCW-1:0]        rc_r, rc_nxt, rc0;
  logic signed [YW-1:0]  y_r, y_nxt, y0;
  logic                  take;

  logic signed [CW:0]        px;
  logic signed [2*CW+1:0]    xx;
  logic signed [2*YW-1:0]    yy;
  logic signed [CW+YW:0]     xy;
  logic signed [CW+ZW:0]     xz;
  logic signed [YW+ZW-1:0]   yz;

  // Product stage
  logic                  p_valid_r, p_clear_r, p_take_r, p_last_r;
  logic signed [SW-1:0]  p_x_r, p_y_r, p_z_r, p_xx_r, p_yy_r, p_xy_r, p_xz_r, p_yz_r;

  ipf_pkg::sums_t sums_r, sums_nxt, base;

  // Coordinates for this request, after an image restart
  always_comb begin
    col0 = first_of_image ? '0 : col_r;
    rc0  = first_of_image ? '0 : rc_r;
    y0   = first_of_image ? '0 : y_r;
    take = sample_valid && (col0 < CW'(MAX_COLUMNS)) && (rc0 < RCW'(MAX_ROWS));
    col_nxt = col0;
    rc_nxt  = rc0;
    y_nxt   = y0;
    if (!last_of_row) begin
      if (col0 < CW'(MAX_COLUMNS)) col_nxt = col0 + CW'(1);
    end else begin
      col_nxt = '0;
      if (rc0 < RCW'(MAX_ROWS)) begin
        rc_nxt = rc0 + RCW'(1);
        y_nxt  = scan_down ? (y0 - YW'(1)) : (y0 + YW'(1));
      end
    end
  end

  // Per-sample products
  always_comb begin
    px = $signed({1'b0, col0});
    xx = px * px;
    yy = y0 * y0;
    xy = px * y0;
    xz = px * sample;
    yz = y0 * sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      rc_r      <= '0;
      y_r       <= '0;
      p_valid_r <= 1'b0;
      p_clear_r <= 1'b0;
      p_take_r  <= 1'b0;
      p_last_r  <= 1'b0;
    end else begin
      p_valid_r <= accept;
      if (accept) begin
        col_r     <= col_nxt;
        rc_r      <= rc_nxt;
        y_r       <= y_nxt;
        p_clear_r <= first_of_image;
        p_take_r  <= take;
        p_last_r  <= last_of_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_x_r  <= SW'(px);
      p_y_r  <= SW'(y0);
      p_z_r  <= SW'(sample);
      p_xx_r <= SW'(xx);
      p_yy_r <= SW'(yy);
      p_xy_r <= SW'(xy);
      p_xz_r <= SW'(xz);
      p_yz_r <= SW'(yz);
    end
  end

  // Sum update
  always_comb begin
    base     = p_clear_r ? '0 : sums_r;
    sums_nxt = base;
    if (p_take_r) begin
      sums_nxt.n   = base.n   + SW'(1);
      sums_nxt.sx  = base.sx  + p_x_r;
      sums_nxt.sy  = base.sy  + p_y_r;
      sums_nxt.sxx = base.sxx + p_xx_r;
      sums_nxt.syy = base.syy + p_yy_r;
      sums_nxt.sxy = base.sxy + p_xy_r;
      sums_nxt.sxz = base.sxz + p_xz_r;
      sums_nxt.syz = base.syz + p_yz_r;
      sums_nxt.sz  = base.sz  + p_z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
    end else if (p_valid_r) begin
      sums_r <= sums_nxt;
    end
  end

  assign solve_go  = p_valid_r && p_last_r;
  assign sums      = sums_r;
  assign row_count = rc_r;

endmodule

>>> hdl/ipf_mac.sv
// ipf_mac: shared bit-serial signed multiply-accumulate, one multiplier bit a cycle.
// Depends on ipf_pkg.
`timescale 1ns / 1ps

module ipf_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ipf_pkg::mac_ctl_t                   ctl,
  input  logic signed [ipf_pkg::ACC_W-1:0]    x_opnd,
  input  logic signed [ipf_pkg::SUM_W-1:0]    b_opnd,
  output logic                                done,
  output logic signed [ipf_pkg::ACC_W-1:0]    acc
);

  localparam int AW    = ipf_pkg::ACC_W;
  localparam int BW    = ipf_pkg::SUM_W;
  localparam int CNT_W = $clog2(BW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BW - 1);

  logic [AW-1:0]    xs_r, acc_r, term;
  logic [BW-1:0]    b_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r, busy_r, done_r, sub;

  // Top multiplier bit carries negative weight
  always_comb begin
    sub  = neg_r ^ (cnt_r == CNT_LAST);
    term = b_r[0] ? (sub ? (~xs_r + AW'(1)) : xs_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      xs_r  <= x_opnd;
      b_r   <= b_opnd;
      neg_r <= ctl.neg;
      if (ctl.clear) acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + term;
      xs_r  <= {xs_r[AW-2:0], 1'b0};
      b_r   <= {1'b0, b_r[BW-1:1]};
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

>>> hdl/ipf_div.sv
// ipf_div: restoring divider, one quotient bit a cycle, with rounding and saturation.
// Depends on ipf_pkg.
`timescale 1ns / 1ps

module ipf_div #(
  parameter int FRAC_BITS = ipf_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [ipf_pkg::ACC_W-1:0]  num,
  input  logic signed [ipf_pkg::ACC_W-1:0]  den,
  output logic                              done,
  output logic [ipf_pkg::QW-1:0]            quot
);

  localparam int AW    = ipf_pkg::ACC_W;
  localparam int QW    = ipf_pkg::QW;
  localparam int DW    = AW + QW;
  localparam int CNT_W = $clog2(QW + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW);

  logic [DW-1:0]    rem_r, ds_r;
  logic [AW-1:0]    d_r, mag_n, mag_d;
  logic [QW:0]      q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r, busy_r, fin_r, done_r, ge, rnd;
  logic [QW+1:0]    qr, lim, u;
  logic [QW-1:0]    quot_r;

  always_comb begin
    mag_n = num[AW-1] ? (~num + AW'(1)) : num;
    mag_d = den[AW-1] ? (~den + AW'(1)) : den;
    ge    = rem_r >= ds_r;
  end

  // Round half away from zero on magnitude, then clamp
  always_comb begin
    rnd = {rem_r[AW-1:0], 1'b0} >= {1'b0, d_r};
    qr  = {1'b0, q_r} + (QW+2)'(rnd);
    lim = neg_r ? ((QW+2)'(1) << (QW-1)) : (((QW+2)'(1) << (QW-1)) - (QW+2)'(1));
    u   = (qr > lim) ? lim : qr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DW'(mag_n) << FRAC_BITS;
      ds_r  <= DW'(mag_d) << QW;
      d_r   <= mag_d;
      q_r   <= '0;
      neg_r <= num[AW-1] ^ den[AW-1];
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - ds_r;
      q_r  <= {q_r[QW-1:0], ge};
      ds_r <= {1'b0, ds_r[DW-1:1]};
    end
    if (fin_r) begin
      quot_r <= neg_r ? (~u[QW-1:0] + QW'(1)) : u[QW-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

>>> hdl/image_plane_fit.sv
// image_plane_fit: streaming least-squares plane fit z = a*x + b*y + c, top level.
// Depends on ipf_pkg, ipf_accum, ipf_mac and ipf_div.
//
//   channel | ports                                   | moves
//   in      | in_valid / in_ready                     | one sample request
//   out     | out_valid / out_ready                   | one fit per closed row
//   cfg     | cfg_we, cfg_wdata                       | scan_down, no wait
//
// A sample without last_of_row leaves in_ready high; samples can stream back to back.
// A row close runs the solve on the shared MAC (24 products for a plane fit) and the
// bit-serial divider, its length set mostly by the MAC's one-bit-per-cycle multiply.
// in_ready stays low until the result is taken. Reset (rst_n low, synchronous) clears
// counters, sums and scan_down.
`timescale 1ns / 1ps

module image_plane_fit #(
  parameter int MAX_COLUMNS = ipf_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = ipf_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS   = ipf_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [ipf_pkg::Z_W-1:0]  in_sample,
  input  logic                            in_sample_valid,
  input  logic                            in_first_of_image,
  input  logic                            in_last_of_row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [ipf_pkg::QW-1:0]   out_slope_x,
  output logic signed [ipf_pkg::QW-1:0]   out_slope_y,
  output logic signed [ipf_pkg::QW-1:0]   out_offset,
  output logic [1:0]                      out_fit_kind,
  output logic [ipf_pkg::RD_W-1:0]        out_rows_done
);

  localparam int AW  = ipf_pkg::ACC_W;
  localparam int SW  = ipf_pkg::SUM_W;
  localparam int QW  = ipf_pkg::QW;
  localparam int SPW = ipf_pkg::STEP_W;
  localparam int RCW = $clog2(MAX_ROWS + 1);

  logic                     scan_down_r;
  logic                     accept, solve_go, mac_done, div_done;
  ipf_pkg::sums_t           sums;
  logic [RCW-1:0]           row_count;
  ipf_pkg::state_t          state_r, state_nxt;
  logic [SPW-1:0]           step_r;
  ipf_pkg::kind_t           kind_r;
  ipf_pkg::ucode_t          uc;
  ipf_pkg::mac_ctl_t        mac_ctl;
  logic signed [AW-1:0]     x_opnd, acc, den;
  logic signed [SW-1:0]     b_opnd;
  logic [AW-1:0]            a11_r, a12_r, a13_r, a22_r, a23_r, a33_r, det_r;
  logic [QW-1:0]            res_a_r, res_b_r, res_c_r, quot;
  logic                     div_start;

  assign accept = in_valid && in_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_down_r <= 1'b0;
    end else if (cfg_we) begin
      scan_down_r <= cfg_wdata;
    end
  end

  ipf_accum #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .sample         (in_sample),
    .sample_valid   (in_sample_valid),
    .first_of_image (in_first_of_image),
    .last_of_row    (in_last_of_row),
    .scan_down      (scan_down_r),
    .solve_go       (solve_go),
    .sums           (sums),
    .row_count      (row_count)
  );

  assign uc = ipf_pkg::ucode(step_r);

  // Operand select for the shared MAC
  always_comb begin
    case (uc.xsel)
      ipf_pkg::OP_N:   x_opnd = AW'($signed(sums.n));
      ipf_pkg::OP_SX:  x_opnd = AW'($signed(sums.sx));
      ipf_pkg::OP_SY:  x_opnd = AW'($signed(sums.sy));
      ipf_pkg::OP_SXX: x_opnd = AW'($signed(sums.sxx));
      ipf_pkg::OP_SYY: x_opnd = AW'($signed(sums.syy));
      ipf_pkg::OP_SXY: x_opnd = AW'($signed(sums.sxy));
      ipf_pkg::OP_SXZ: x_opnd = AW'($signed(sums.sxz));
      ipf_pkg::OP_SYZ: x_opnd = AW'($signed(sums.syz));
      ipf_pkg::OP_SZ:  x_opnd = AW'($signed(sums.sz));
      ipf_pkg::OP_A11: x_opnd = a11_r;
      ipf_pkg::OP_A12: x_opnd = a12_r;
      ipf_pkg::OP_A13: x_opnd = a13_r;
      ipf_pkg::OP_A22: x_opnd = a22_r;
      ipf_pkg::OP_A23: x_opnd = a23_r;
      ipf_pkg::OP_A33: x_opnd = a33_r;
      default:         x_opnd = '0;
    endcase
    case (uc.bsel)
      ipf_pkg::OP_N:   b_opnd = sums.n;
      ipf_pkg::OP_SX:  b_opnd = sums.sx;
      ipf_pkg::OP_SY:  b_opnd = sums.sy;
      ipf_pkg::OP_SXX: b_opnd = sums.sxx;
      ipf_pkg::OP_SYY: b_opnd = sums.syy;
      ipf_pkg::OP_SXY: b_opnd = sums.sxy;
      ipf_pkg::OP_SXZ: b_opnd = sums.sxz;
      ipf_pkg::OP_SYZ: b_opnd = sums.syz;
      ipf_pkg::OP_SZ:  b_opnd = sums.sz;
      default:         b_opnd = '0;
    endcase
  end

  ipf_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .x_opnd (x_opnd),
    .b_opnd (b_opnd),
    .done   (mac_done),
    .acc    (acc)
  );

  assign den = (kind_r == ipf_pkg::KIND_PLANE) ? det_r : a22_r;

  ipf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ipf_pkg::S_IDLE:  if (solve_go) state_nxt = ipf_pkg::S_ISSUE;
      ipf_pkg::S_ISSUE: state_nxt = ipf_pkg::S_MAC;
      ipf_pkg::S_MAC: begin
        if (mac_done) begin
          if (!uc.last) begin
            state_nxt = ipf_pkg::S_ISSUE;
          end else if (uc.dest == ipf_pkg::D_NUM) begin
            state_nxt = ipf_pkg::S_DIVGO;
          end else if (uc.dest == ipf_pkg::D_DET) begin
            state_nxt = ((acc != '0) || (a22_r != '0)) ? ipf_pkg::S_ISSUE : ipf_pkg::S_OUT;
          end else begin
            state_nxt = ipf_pkg::S_ISSUE;
          end
        end
      end
      ipf_pkg::S_DIVGO: state_nxt = ipf_pkg::S_DIV;
      ipf_pkg::S_DIV: begin
        if (div_done) state_nxt = uc.done ? ipf_pkg::S_OUT : ipf_pkg::S_ISSUE;
      end
      ipf_pkg::S_OUT:   if (out_ready) state_nxt = ipf_pkg::S_IDLE;
      default:          state_nxt = ipf_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    mac_ctl.start = (state_r == ipf_pkg::S_ISSUE);
    mac_ctl.clear = uc.first;
    mac_ctl.neg   = uc.neg;
    div_start     = (state_r == ipf_pkg::S_DIVGO);
    out_valid     = (state_r == ipf_pkg::S_OUT);
    in_ready      = (state_r == ipf_pkg::S_IDLE) && !solve_go;
  end

  // Control registers: state, step and fit kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipf_pkg::S_IDLE;
      step_r  <= '0;
      kind_r  <= ipf_pkg::KIND_NONE;
    end else begin
      state_r <= state_nxt;
      if (state_r == ipf_pkg::S_IDLE && solve_go) begin
        step_r <= '0;
        kind_r <= ipf_pkg::KIND_NONE;
      end else if (state_r == ipf_pkg::S_MAC && mac_done) begin
        if (uc.dest == ipf_pkg::D_DET && uc.last) begin
          if (acc != '0) begin
            kind_r <= ipf_pkg::KIND_PLANE;
            step_r <= step_r + SPW'(1);
          end else if (a22_r != '0) begin
            kind_r <= ipf_pkg::KIND_LINE;
            step_r <= ipf_pkg::LINE_START;
          end
        end else if (uc.dest != ipf_pkg::D_NUM || !uc.last) begin
          step_r <= step_r + SPW'(1);
        end
      end else if (state_r == ipf_pkg::S_DIV && div_done && !uc.done) begin
        step_r <= step_r + SPW'(1);
      end
    end
  end

  // Cofactors, determinant and results
  always_ff @(posedge clk) begin
    if (state_r == ipf_pkg::S_IDLE && solve_go) begin
      res_a_r <= '0;
      res_b_r <= '0;
      res_c_r <= '0;
    end
    if (state_r == ipf_pkg::S_MAC && mac_done && uc.last) begin
      case (uc.dest)
        ipf_pkg::D_A11: a11_r <= acc;
        ipf_pkg::D_A12: a12_r <= acc;
        ipf_pkg::D_A13: a13_r <= acc;
        ipf_pkg::D_A22: a22_r <= acc;
        ipf_pkg::D_A23: a23_r <= acc;
        ipf_pkg::D_A33: a33_r <= acc;
        ipf_pkg::D_DET: det_r <= acc;
        default: ;
      endcase
    end
    if (state_r == ipf_pkg::S_DIV && div_done) begin
      case (uc.slot)
        ipf_pkg::SL_A: res_a_r <= quot;
        ipf_pkg::SL_B: res_b_r <= quot;
        ipf_pkg::SL_C: res_c_r <= quot;
        default: ;
      endcase
    end
  end

  assign out_slope_x   = res_a_r;
  assign out_slope_y   = res_b_r;
  assign out_offset    = res_c_r;
  assign out_fit_kind  = kind_r;
  assign out_rows_done = ipf_pkg::RD_W'(row_count);

`ifndef SYNTHESIS
  // No new sample while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken during output");
  // No fit means all-zero results
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fit_kind == ipf_pkg::KIND_NONE) |->
      (out_slope_x == '0 && out_slope_y == '0 && out_offset == '0))
    else $error("nonzero result without fit");
  // Line fallback never produces a y slope
  a_line_noy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fit_kind == ipf_pkg::KIND_LINE) |-> out_slope_y == '0)
    else $error("y slope on line fit");
  // The MAC is only started from a stable solve context
  a_mac_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    mac_ctl.start |=> state_r == ipf_pkg::S_MAC)
    else $error("MAC start outside issue");
`endif

endmodule
